/* rtl/csr_matrix_transpose_assert.svh */
// Assertion macros for the sparse matrix transpose block.
// Each macro expands to one labelled concurrent assertion, clocked on clk and off in reset.
`ifndef CSR_MATRIX_TRANSPOSE_ASSERT_SVH
`define CSR_MATRIX_TRANSPOSE_ASSERT_SVH

// Condition that must hold at every clock edge.
`define CTM_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Condition that must hold at the clock edge after the trigger.
`define CTM_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

// Condition that must hold at the same clock edge as the trigger.
`define CTM_ASSERT_SAME(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

`endif

/* rtl/ctm_pkg.sv */
// Shared codes and field widths for the sparse matrix transpose block.
// Depends on nothing; imported by the top level.
`timescale 1ns / 1ps

package ctm_pkg;

    localparam int ROW_BITS    = 10;
    localparam int COL_BITS    = 10;
    localparam int INDEX_BITS  = 12;
    localparam int CFG_BITS    = 11;
    localparam int START_BITS  = 13;
    localparam int TOTAL_BITS  = 13;
    localparam int PORT_VALUE_BITS = 64;

    typedef logic [1:0] mode_t;
    typedef logic [1:0] status_t;

    localparam mode_t MODE_LOAD   = 2'd0;
    localparam mode_t MODE_FINISH = 2'd1;
    localparam mode_t MODE_START  = 2'd2;
    localparam mode_t MODE_ENTRY  = 2'd3;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_BAD   = 2'd1;
    localparam status_t ST_EARLY = 2'd2;
    localparam status_t ST_RANGE = 2'd3;

    localparam logic REG_NUM_ROWS = 1'b0;
    localparam logic REG_NUM_COLS = 1'b1;

endpackage

/* rtl/ctm_ram.sv */
// Simple synchronous memory: one write port, one read port, registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module ctm_ram #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 1
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/csr_matrix_transpose.sv */
// Sparse matrix transpose in compressed-row form: sequencer, registers and memories.
// Depends on ctm_pkg, ctm_ram and the assertion macro header.
`timescale 1ns / 1ps
// How to use this block.
// Requests arrive on the in channel (in_valid/in_ready) with a mode and its fields;
// every request gives exactly one result on the out channel (out_valid/out_ready).
// The cfg channel writes num_rows (index 0) or num_cols (index 1); it is always ready
// and should only be used while no request is in flight.
// The finish is set by a walk over the column count memory, one column per cycle,
// followed by a scatter that steps through three states per nonzero on the entry store
// and the fill cursor memory. One request is worked on at a time; the next one is
// taken as soon as the sequencer is idle, even while the previous result waits.
// If the receiver stalls, a finished result waits in a staging register until the
// output register frees, and no new request is taken meanwhile.
// After reset the block sweeps the column count memory to zero, one entry per
// cycle, across all MAX_DIM entries; in_ready stays low during the sweep.
// Configuration writes are accepted during the sweep. Both registers reset to 1024.

`include "csr_matrix_transpose_assert.svh"

module csr_matrix_transpose #(
    parameter int MAX_DIM     = 1024,
    parameter int MAX_NONZERO = 4096,
    parameter int VALUE_BITS  = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic                               cfg_index,
    input  logic [ctm_pkg::CFG_BITS-1:0]       cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  ctm_pkg::mode_t                     mode,
    input  logic [ctm_pkg::ROW_BITS-1:0]       src_row,
    input  logic [ctm_pkg::COL_BITS-1:0]       src_col,
    input  logic [ctm_pkg::PORT_VALUE_BITS-1:0] src_value,
    input  logic [ctm_pkg::INDEX_BITS-1:0]     read_index,
    output logic                               out_valid,
    input  logic                               out_ready,
    output ctm_pkg::status_t                   status,
    output logic [ctm_pkg::START_BITS-1:0]     row_start,
    output logic [ctm_pkg::COL_BITS-1:0]       entry_col,
    output logic [ctm_pkg::PORT_VALUE_BITS-1:0] entry_value,
    output logic [ctm_pkg::TOTAL_BITS-1:0]     nonzero_total
);

    import ctm_pkg::*;

    localparam int AW  = $clog2(MAX_DIM);
    localparam int PW  = $clog2(MAX_DIM + 1);
    localparam int NA  = $clog2(MAX_NONZERO);
    localparam int NW  = $clog2(MAX_NONZERO + 1);
    localparam int EW  = (PW > INDEX_BITS) ? PW : INDEX_BITS;
    localparam int IW  = (NW > INDEX_BITS) ? NW : INDEX_BITS;
    localparam int SW  = ROW_BITS + COL_BITS + VALUE_BITS;
    localparam int OW  = ROW_BITS + VALUE_BITS;

    // Sequencer states.
    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_LOAD_WR = 4'd2;
    localparam logic [3:0] S_PRE     = 4'd3;
    localparam logic [3:0] S_SC_A    = 4'd4;
    localparam logic [3:0] S_SC_B    = 4'd5;
    localparam logic [3:0] S_SC_C    = 4'd6;
    localparam logic [3:0] S_FIN     = 4'd7;
    localparam logic [3:0] S_READ    = 4'd8;
    localparam logic [3:0] S_OUT     = 4'd9;

    logic [3:0]           state_reg, state_next;
    logic [CFG_BITS-1:0]  nrows_reg, ncols_reg;
    logic [NW-1:0]        loaded_reg, loaded_next;
    logic                 finished_reg, finished_next;
    logic                 overflow_reg, overflow_next;
    logic [PW-1:0]        cnt_reg, cnt_next;
    logic                 pend_reg, pend_next;
    logic [AW-1:0]        paddr_reg, paddr_next;
    logic [NW-1:0]        sum_reg, sum_next;
    logic [NW-1:0]        scan_reg, scan_next;
    logic                 kind_reg, kind_next;
    logic                 out_valid_reg, out_valid_next;

    // Payload registers.
    logic [ROW_BITS-1:0]   ent_row_reg, ent_row_next;
    logic [AW-1:0]         ent_col_reg, ent_col_next;
    logic [VALUE_BITS-1:0] ent_val_reg, ent_val_next;
    status_t               res_status_reg, res_status_next;
    logic [START_BITS-1:0] res_start_reg, res_start_next;
    logic [COL_BITS-1:0]   res_col_reg, res_col_next;
    logic [VALUE_BITS-1:0] res_val_reg, res_val_next;
    status_t               out_status_reg, out_status_next;
    logic [START_BITS-1:0] out_start_reg, out_start_next;
    logic [COL_BITS-1:0]   out_col_reg, out_col_next;
    logic [VALUE_BITS-1:0] out_val_reg, out_val_next;
    logic [TOTAL_BITS-1:0] out_total_reg, out_total_next;

    // Memory ports.
    logic          cnt_we, cnt_re;
    logic [AW-1:0] cnt_waddr, cnt_raddr;
    logic [NW-1:0] cnt_wdata, cnt_rdata;
    logic          in_we, in_re;
    logic [NA-1:0] in_waddr, in_raddr;
    logic [SW-1:0] in_wdata, in_rdata;
    logic          start_we, start_re;
    logic [AW-1:0] start_raddr;
    logic [NW-1:0] start_rdata;
    logic          cur_we, cur_re;
    logic [AW-1:0] cur_waddr, cur_raddr;
    logic [NW-1:0] cur_wdata, cur_rdata;
    logic          out_we, out_re;
    logic [NA-1:0] out_waddr, out_raddr;
    logic [OW-1:0] out_wdata, out_rdata;

    // Effective dimensions: zero acts as one, anything above MAX_DIM as MAX_DIM.
    logic [EW-1:0] nr_eff, nc_eff;
    logic [NW-1:0] base_count;
    logic          load_bad;
    logic          accept;

    always_comb
    begin
        if (nrows_reg == '0)
            nr_eff = EW'(1);
        else if (EW'(nrows_reg) > EW'(MAX_DIM))
            nr_eff = EW'(MAX_DIM);
        else
            nr_eff = EW'(nrows_reg);
        if (ncols_reg == '0)
            nc_eff = EW'(1);
        else if (EW'(ncols_reg) > EW'(MAX_DIM))
            nc_eff = EW'(MAX_DIM);
        else
            nc_eff = EW'(ncols_reg);
    end

    // A load after a finish starts a fresh matrix; the counts were zeroed by the finish.
    assign base_count = finished_reg ? '0 : loaded_reg;
    assign load_bad   = (EW'(src_row) >= nr_eff) || (EW'(src_col) >= nc_eff)
                     || (base_count >= NW'(MAX_NONZERO));

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        loaded_next     = loaded_reg;
        finished_next   = finished_reg;
        overflow_next   = overflow_reg;
        cnt_next        = cnt_reg;
        pend_next       = 1'b0;
        paddr_next      = paddr_reg;
        sum_next        = sum_reg;
        scan_next       = scan_reg;
        kind_next       = kind_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        ent_row_next    = ent_row_reg;
        ent_col_next    = ent_col_reg;
        ent_val_next    = ent_val_reg;
        res_status_next = res_status_reg;
        res_start_next  = res_start_reg;
        res_col_next    = res_col_reg;
        res_val_next    = res_val_reg;
        out_status_next = out_status_reg;
        out_start_next  = out_start_reg;
        out_col_next    = out_col_reg;
        out_val_next    = out_val_reg;
        out_total_next  = out_total_reg;

        cnt_we    = 1'b0;
        cnt_waddr = '0;
        cnt_wdata = '0;
        cnt_re    = 1'b0;
        cnt_raddr = '0;
        in_we     = 1'b0;
        in_waddr  = '0;
        in_wdata  = '0;
        in_re     = 1'b0;
        in_raddr  = '0;
        start_we  = 1'b0;
        start_re  = 1'b0;
        start_raddr = '0;
        cur_we    = 1'b0;
        cur_waddr = '0;
        cur_wdata = '0;
        cur_re    = 1'b0;
        cur_raddr = '0;
        out_we    = 1'b0;
        out_waddr = '0;
        out_wdata = '0;
        out_re    = 1'b0;
        out_raddr = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = AW'(cnt_reg);
                cnt_next  = cnt_reg + PW'(1);
                if (cnt_reg == PW'(MAX_DIM - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    res_status_next = ST_OK;
                    res_start_next  = '0;
                    res_col_next    = '0;
                    res_val_next    = '0;
                    case (mode)
                        MODE_LOAD:
                        begin
                            finished_next = 1'b0;
                            if (load_bad)
                            begin
                                overflow_next   = 1'b1;
                                loaded_next     = base_count;
                                res_status_next = ST_BAD;
                                state_next      = S_OUT;
                            end
                            else
                            begin
                                in_we         = 1'b1;
                                in_waddr      = NA'(base_count);
                                in_wdata      = {src_row, src_col, src_value[VALUE_BITS-1:0]};
                                cnt_re        = 1'b1;
                                cnt_raddr     = AW'(src_col);
                                ent_col_next  = AW'(src_col);
                                loaded_next   = base_count + NW'(1);
                                overflow_next = finished_reg ? 1'b0 : overflow_reg;
                                state_next    = S_LOAD_WR;
                            end
                        end
                        MODE_FINISH:
                        begin
                            if (finished_reg)
                            begin
                                // Nothing changed since the last finish: same transpose.
                                res_status_next = overflow_reg ? ST_BAD : ST_OK;
                                state_next      = S_OUT;
                            end
                            else
                            begin
                                cnt_next   = '0;
                                sum_next   = '0;
                                state_next = S_PRE;
                            end
                        end
                        default:
                        begin
                            kind_next = (mode == MODE_START);
                            if (!finished_reg)
                            begin
                                res_status_next = ST_EARLY;
                                state_next      = S_OUT;
                            end
                            else if (mode == MODE_START)
                            begin
                                if (EW'(read_index) >= nc_eff)
                                begin
                                    res_status_next = ST_RANGE;
                                    state_next      = S_OUT;
                                end
                                else
                                begin
                                    start_re    = 1'b1;
                                    start_raddr = AW'(read_index);
                                    state_next  = S_READ;
                                end
                            end
                            else
                            begin
                                if (IW'(read_index) >= IW'(loaded_reg))
                                begin
                                    res_status_next = ST_RANGE;
                                    state_next      = S_OUT;
                                end
                                else
                                begin
                                    out_re     = 1'b1;
                                    out_raddr  = NA'(read_index);
                                    state_next = S_READ;
                                end
                            end
                        end
                    endcase
                end
            end
            S_LOAD_WR:
            begin
                cnt_we     = 1'b1;
                cnt_waddr  = ent_col_reg;
                cnt_wdata  = cnt_rdata + NW'(1);
                state_next = S_OUT;
            end
            S_PRE:
            begin
                // Read column counts in order; in the following cycle record the running sum
                // as row start and fill cursor, and zero the count for the next matrix.
                if (cnt_reg < PW'(MAX_DIM))
                begin
                    cnt_re    = 1'b1;
                    cnt_raddr = AW'(cnt_reg);
                    pend_next = 1'b1;
                    cnt_next  = cnt_reg + PW'(1);
                end
                paddr_next = AW'(cnt_reg);
                if (pend_reg)
                begin
                    start_we  = 1'b1;
                    cur_we    = 1'b1;
                    cur_waddr = paddr_reg;
                    cur_wdata = sum_reg;
                    cnt_we    = 1'b1;
                    cnt_waddr = paddr_reg;
                    cnt_wdata = '0;
                    sum_next  = sum_reg + cnt_rdata;
                end
                if (cnt_reg == PW'(MAX_DIM) && pend_reg)
                begin
                    scan_next  = '0;
                    state_next = (loaded_reg == '0) ? S_FIN : S_SC_A;
                end
            end
            S_SC_A:
            begin
                in_re      = 1'b1;
                in_raddr   = NA'(scan_reg);
                state_next = S_SC_B;
            end
            S_SC_B:
            begin
                ent_row_next = in_rdata[SW-1 -: ROW_BITS];
                ent_col_next = AW'(in_rdata[VALUE_BITS +: COL_BITS]);
                ent_val_next = in_rdata[VALUE_BITS-1:0];
                cur_re       = 1'b1;
                cur_raddr    = AW'(in_rdata[VALUE_BITS +: COL_BITS]);
                state_next   = S_SC_C;
            end
            S_SC_C:
            begin
                out_we    = 1'b1;
                out_waddr = NA'(cur_rdata);
                out_wdata = {ent_row_reg, ent_val_reg};
                cur_we    = 1'b1;
                cur_waddr = ent_col_reg;
                cur_wdata = cur_rdata + NW'(1);
                scan_next = scan_reg + NW'(1);
                state_next = (scan_reg + NW'(1) == loaded_reg) ? S_FIN : S_SC_A;
            end
            S_FIN:
            begin
                finished_next   = 1'b1;
                res_status_next = overflow_reg ? ST_BAD : ST_OK;
                state_next      = S_OUT;
            end
            S_READ:
            begin
                if (kind_reg)
                begin
                    res_start_next = START_BITS'(start_rdata);
                end
                else
                begin
                    res_col_next = out_rdata[OW-1 -: ROW_BITS];
                    res_val_next = out_rdata[VALUE_BITS-1:0];
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_start_next  = res_start_reg;
                    out_col_next    = res_col_reg;
                    out_val_next    = res_val_reg;
                    out_total_next  = TOTAL_BITS'(loaded_reg);
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            nrows_reg     <= CFG_BITS'(1024);
            ncols_reg     <= CFG_BITS'(1024);
            loaded_reg    <= '0;
            finished_reg  <= 1'b0;
            overflow_reg  <= 1'b0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            loaded_reg    <= loaded_next;
            finished_reg  <= finished_next;
            overflow_reg  <= overflow_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_NUM_ROWS)
                    nrows_reg <= cfg_data;
                else
                    ncols_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        paddr_reg      <= paddr_next;
        sum_reg        <= sum_next;
        scan_reg       <= scan_next;
        kind_reg       <= kind_next;
        ent_row_reg    <= ent_row_next;
        ent_col_reg    <= ent_col_next;
        ent_val_reg    <= ent_val_next;
        res_status_reg <= res_status_next;
        res_start_reg  <= res_start_next;
        res_col_reg    <= res_col_next;
        res_val_reg    <= res_val_next;
        out_status_reg <= out_status_next;
        out_start_reg  <= out_start_next;
        out_col_reg    <= out_col_next;
        out_val_reg    <= out_val_next;
        out_total_reg  <= out_total_next;
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign row_start     = out_start_reg;
    assign entry_col     = out_col_reg;
    assign entry_value   = PORT_VALUE_BITS'(out_val_reg);
    assign nonzero_total = out_total_reg;

    // Column counts of the matrix being loaded.
    ctm_ram #(.DEPTH(MAX_DIM), .WIDTH(NW)) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    // Loaded nonzeros in arrival order: row, column, value.
    ctm_ram #(.DEPTH(MAX_NONZERO), .WIDTH(SW)) u_in_ram (
        .clk   (clk),
        .we    (in_we),
        .waddr (in_waddr),
        .wdata (in_wdata),
        .re    (in_re),
        .raddr (in_raddr),
        .rdata (in_rdata)
    );

    // Row starts of the result.
    ctm_ram #(.DEPTH(MAX_DIM), .WIDTH(NW)) u_start_ram (
        .clk   (clk),
        .we    (start_we),
        .waddr (paddr_reg),
        .wdata (sum_reg),
        .re    (start_re),
        .raddr (start_raddr),
        .rdata (start_rdata)
    );

    // Fill cursor per result row, used during the scatter.
    ctm_ram #(.DEPTH(MAX_DIM), .WIDTH(NW)) u_cursor_ram (
        .clk   (clk),
        .we    (cur_we),
        .waddr (cur_waddr),
        .wdata (cur_wdata),
        .re    (cur_re),
        .raddr (cur_raddr),
        .rdata (cur_rdata)
    );

    // Transposed entries: source row and value.
    ctm_ram #(.DEPTH(MAX_NONZERO), .WIDTH(OW)) u_out_ram (
        .clk   (clk),
        .we    (out_we),
        .waddr (out_waddr),
        .wdata (out_wdata),
        .re    (out_re),
        .raddr (out_raddr),
        .rdata (out_rdata)
    );

    `CTM_ASSERT_ALWAYS(a_count_bound, loaded_reg <= NW'(MAX_NONZERO), "nonzero count overrun")
    `CTM_ASSERT_SAME(a_finish_src, $rose(finished_reg), $past(state_reg) == S_FIN,
        "finish flag set outside the finish step")
    `CTM_ASSERT_NEXT(a_early_read,
        accept && mode != MODE_LOAD && mode != MODE_FINISH && !finished_reg,
        res_status_reg == ST_EARLY, "read before finish not flagged")

endmodule

/* tb/csr_matrix_transpose_tb.sv */
// Self-checking testbench for the compressed-row sparse matrix transpose block.
// Depends on ctm_pkg and the csr_matrix_transpose RTL, which needs ctm_ram and the macro header.
`timescale 1ns / 1ps

module csr_matrix_transpose_tb;
    import ctm_pkg::*;

    localparam int DIM_LIMIT = 1024;
    localparam int NZ_LIMIT  = 4096;

    // One result as the block presents it on its output channel.
    typedef struct packed {
        status_t                     status;
        logic [START_BITS-1:0]       row_start;
        logic [COL_BITS-1:0]         entry_col;
        logic [PORT_VALUE_BITS-1:0]  entry_value;
        logic [TOTAL_BITS-1:0]       nonzero_total;
    } transpose_result_t;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic                         cfg_index;
    logic [CFG_BITS-1:0]          cfg_data;
    logic                         in_valid;
    logic                         in_ready;
    mode_t                        mode;
    logic [ROW_BITS-1:0]          src_row;
    logic [COL_BITS-1:0]          src_col;
    logic [PORT_VALUE_BITS-1:0]   src_value;
    logic [INDEX_BITS-1:0]        read_index;
    logic                         out_valid;
    logic                         out_ready;
    status_t                      status;
    logic [START_BITS-1:0]        row_start;
    logic [COL_BITS-1:0]          entry_col;
    logic [PORT_VALUE_BITS-1:0]   entry_value;
    logic [TOTAL_BITS-1:0]        nonzero_total;

    csr_matrix_transpose dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .src_row       (src_row),
        .src_col       (src_col),
        .src_value     (src_value),
        .read_index    (read_index),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .row_start     (row_start),
        .entry_col     (entry_col),
        .entry_value   (entry_value),
        .nonzero_total (nonzero_total)
    );

    // Shadow copy of the block's registers and memories, kept up to date as
    // each request is accepted.
    logic [CFG_BITS-1:0]    shadow_rows;
    logic [CFG_BITS-1:0]    shadow_cols;
    logic [ROW_BITS-1:0]    nz_row_mem   [NZ_LIMIT];
    logic [COL_BITS-1:0]    nz_col_mem   [NZ_LIMIT];
    logic [63:0]            nz_value_mem [NZ_LIMIT];
    logic [START_BITS-1:0]  col_tally    [DIM_LIMIT];
    logic [START_BITS-1:0]  t_row_starts [DIM_LIMIT];
    logic [COL_BITS-1:0]    t_col_mem    [NZ_LIMIT];
    logic [63:0]            t_value_mem  [NZ_LIMIT];
    int                     nz_loaded;
    bit                     transposed;
    bit                     load_rejected;

    transpose_result_t      pending_results[$];
    int                     fail_count;
    int                     request_count;
    int                     result_count;
    int                     finish_count;
    int                     hold_left;
    bit                     quiet;

    // Effective dimension: zero reads as one, anything above the limit is clamped.
    function automatic int clamp_dim(logic [CFG_BITS-1:0] v);
        if (v == 0)
            return 1;
        if (v > DIM_LIMIT)
            return DIM_LIMIT;
        return int'(v);
    endfunction

    // Forms the transposed matrix: exclusive prefix sum of the column tallies
    // over every column, then a stable scatter of the stored nonzeros.
    function automatic void form_transpose();
        int cursor [DIM_LIMIT];
        int sum;
        int pos;
        sum = 0;
        for (int c = 0; c < DIM_LIMIT; c++)
        begin
            t_row_starts[c] = sum[START_BITS-1:0];
            cursor[c] = sum;
            sum += col_tally[c];
        end
        for (int i = 0; i < nz_loaded; i++)
        begin
            pos = cursor[nz_col_mem[i]];
            cursor[nz_col_mem[i]] = pos + 1;
            if (pos < NZ_LIMIT)
            begin
                t_col_mem[pos]   = nz_row_mem[i];
                t_value_mem[pos] = nz_value_mem[i];
            end
        end
        transposed = 1'b1;
    endfunction

    // Works out the result of one accepted request and updates the shadow state.
    function automatic transpose_result_t transpose_outcome(mode_t m, logic [9:0] r,
                                                           logic [9:0] c, logic [63:0] v,
                                                           logic [11:0] idx);
        transpose_result_t res;
        int nr;
        int nc;
        nr = clamp_dim(shadow_rows);
        nc = clamp_dim(shadow_cols);
        res = '0;
        res.status = ST_OK;
        if (m == MODE_LOAD)
        begin
            // A load after a finish starts a fresh matrix.
            if (transposed)
            begin
                for (int k = 0; k < DIM_LIMIT; k++)
                    col_tally[k] = '0;
                nz_loaded = 0;
                transposed = 1'b0;
                load_rejected = 1'b0;
            end
            if (r >= nr || c >= nc || nz_loaded >= NZ_LIMIT)
            begin
                load_rejected = 1'b1;
                res.status = ST_BAD;
            end
            else
            begin
                nz_row_mem[nz_loaded]   = r;
                nz_col_mem[nz_loaded]   = c;
                nz_value_mem[nz_loaded] = v;
                col_tally[c] = col_tally[c] + 1'b1;
                nz_loaded++;
            end
        end
        else if (m == MODE_FINISH)
        begin
            form_transpose();
            res.status = load_rejected ? ST_BAD : ST_OK;
        end
        else if (!transposed)
            res.status = ST_EARLY;
        else if (m == MODE_START)
        begin
            if (idx >= nc)
                res.status = ST_RANGE;
            else
                res.row_start = t_row_starts[idx[9:0]];
        end
        else
        begin
            if (idx >= nz_loaded)
                res.status = ST_RANGE;
            else
            begin
                res.entry_col   = t_col_mem[idx];
                res.entry_value = t_value_mem[idx];
            end
        end
        res.nonzero_total = nz_loaded[TOTAL_BITS-1:0];
        return res;
    endfunction

    // Clock and reset.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Receiver: accepts results at random, except during an imposed hold-off, when it
    // is never ready, or a quiet stretch, when it is always ready.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                out_ready <= 1'b0;
            end
            else if (quiet)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 99) >= 31);
        end
    end

    // Result checker: every accepted result is matched against the oldest
    // expectation, field by field.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with nothing expected: status %0d", status);
                fail_count++;
            end
            else
            begin
                transpose_result_t exp_res;
                exp_res = pending_results.pop_front();
                result_count++;
                if (status !== exp_res.status)
                begin
                    $error("status: expected %0d, got %0d", exp_res.status, status);
                    fail_count++;
                end
                if (row_start !== exp_res.row_start)
                begin
                    $error("row_start: expected %0d, got %0d", exp_res.row_start, row_start);
                    fail_count++;
                end
                if (entry_col !== exp_res.entry_col)
                begin
                    $error("entry_col: expected %0d, got %0d", exp_res.entry_col, entry_col);
                    fail_count++;
                end
                if (entry_value !== exp_res.entry_value)
                begin
                    $error("entry_value: expected %h, got %h", exp_res.entry_value,
                           entry_value);
                    fail_count++;
                end
                if (nonzero_total !== exp_res.nonzero_total)
                begin
                    $error("nonzero_total: expected %0d, got %0d", exp_res.nonzero_total,
                           nonzero_total);
                    fail_count++;
                end
            end
        end
    end

    // Sends one request. A random gap may come first; valid is only lowered
    // during such a gap or while the block is drained, never in the step that
    // raises it.
    task automatic send_request(mode_t m, logic [9:0] r, logic [9:0] c, logic [63:0] v,
                                logic [11:0] idx);
        int gap;
        if (!quiet && $urandom_range(0, 99) < 31)
        begin
            gap = $urandom_range(1, 6);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid   <= 1'b1;
        mode       <= m;
        src_row    <= r;
        src_col    <= c;
        src_value  <= v;
        read_index <= idx;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(transpose_outcome(m, r, c, v, idx));
        request_count++;
        if (m == MODE_FINISH)
            finish_count++;
    endtask

    task automatic send_load(int r, int c, logic [63:0] v);
        send_request(MODE_LOAD, r[9:0], c[9:0], v, '0);
    endtask

    task automatic send_read(mode_t m, int idx);
        send_request(m, '0, '0, '0, idx[11:0]);
    endtask

    // Lowers valid and waits until every expected result has come back, then
    // leaves a margin for a request still being worked on.
    task automatic drain_block();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Writes one register; only done once the block has been drained.
    task automatic write_register(logic idx, logic [CFG_BITS-1:0] value);
        drain_block();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_NUM_ROWS)
            shadow_rows = value;
        else
            shadow_cols = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_shape(logic [CFG_BITS-1:0] nr, logic [CFG_BITS-1:0] nc);
        write_register(REG_NUM_ROWS, nr);
        write_register(REG_NUM_COLS, nc);
    endtask

    // Reads before any finish, then a finish of an empty matrix and the
    // extremes of the read indexes.
    task automatic test_early_reads();
        send_read(MODE_START, 0);
        send_read(MODE_ENTRY, 0);
        send_request(MODE_FINISH, '0, '0, '0, '0);
        send_read(MODE_START, 1023);
        send_read(MODE_START, 4095);
        send_read(MODE_ENTRY, 0);
    endtask

    // Field extremes, rows out of order, a rejected load, a repeated finish
    // and a load after finish.
    task automatic test_directed_cases();
        set_shape(11'd1024, 11'd1024);
        send_load(0, 1023, 64'hFFFF_FFFF_FFFF_FFFF);
        send_load(0, 0, 64'h0);
        send_load(1023, 1023, 64'hA5A5_5A5A_0F0F_F0F0);
        send_load(512, 0, 64'h8000_0000_0000_0001);
        send_load(3, 1023, 64'h0123_4567_89AB_CDEF);
        send_request(MODE_FINISH, '0, '0, '0, '0);
        send_request(MODE_FINISH, '0, '0, '0, '0);
        send_read(MODE_START, 1);
        send_read(MODE_START, 1023);
        for (int i = 0; i < 6; i++)
            send_read(MODE_ENTRY, i);
        // Zero reads as one row, so row 1 is out of range and rejected.
        set_shape(11'd0, 11'd2047);
        send_load(0, 5, 64'h1);
        send_load(1, 5, 64'h2);
        send_load(0, 1023, 64'h3);
        send_request(MODE_FINISH, '0, '0, '0, '0);
        send_read(MODE_START, 1024);
        send_read(MODE_ENTRY, 1);
        send_read(MODE_ENTRY, 2);
    endtask

    // Shrinking the column count after loading: every stored entry keeps its
    // place, but row-start reads follow the new bound.
    task automatic test_register_change();
        set_shape(11'd2047, 11'd2047);
        send_load(7, 900, 64'hDEAD_BEEF_0000_0007);
        send_load(8, 2, 64'hCAFE_F00D_0000_0008);
        set_shape(11'd2047, 11'd4);
        send_request(MODE_FINISH, '0, '0, '0, '0);
        send_read(MODE_START, 3);
        send_read(MODE_START, 4);
        send_read(MODE_ENTRY, 1);
    endtask

    // The receiver holds off for a long stretch while loads keep coming, so
    // the block fills up and stalls its input.
    task automatic test_backpressure();
        set_shape(11'd64, 11'd64);
        hold_left = 300;
        for (int i = 0; i < 40; i++)
            send_load(i, $urandom_range(0, 63), {$urandom, $urandom});
        send_request(MODE_FINISH, '0, '0, '0, '0);
        send_read(MODE_ENTRY, 39);
    endtask

    // A long run of loads and reads with no idling on either side.
    task automatic test_full_rate();
        set_shape(11'd1024, 11'd1024);
        quiet = 1'b1;
        for (int i = 0; i < 64; i++)
            send_load(i, $urandom_range(0, 1023), {$urandom, $urandom});
        send_request(MODE_FINISH, '0, '0, '0, '0);
        for (int j = 0; j < 16; j++)
            send_read(MODE_ENTRY, j * 4);
        send_read(MODE_ENTRY, 64);
        send_read(MODE_START, 1023);
        drain_block();
        quiet = 1'b0;
    endtask

    // Random matrices: mostly well-formed loads in row order with random
    // content, some rejected or out-of-order loads, then a finish and reads.
    task automatic test_random_matrices();
        int nr;
        int nc;
        int row;
        int col;
        int loads;
        int reads;
        for (int p = 0; p < 12; p++)
        begin
            case (p)
                0: set_shape(11'd2047, 11'd0);
                1: set_shape(11'd0, 11'd2047);
                2: set_shape(11'd1024, 11'd1024);
                default:
                    if (p % 4 == 3)
                        set_shape(CFG_BITS'($urandom_range(1, 2047)),
                                  CFG_BITS'($urandom_range(1, 2047)));
                    else
                        set_shape(CFG_BITS'($urandom_range(1, 24)),
                                  CFG_BITS'($urandom_range(1, 24)));
            endcase
            nr = clamp_dim(shadow_rows);
            nc = clamp_dim(shadow_cols);
            loads = $urandom_range(10, 60);
            reads = $urandom_range(15, 45);
            if ($urandom_range(0, 3) == 0)
                send_read(MODE_ENTRY, $urandom_range(0, 4095));
            row = 0;
            for (int i = 0; i < loads; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_load($urandom_range(0, 1023), $urandom_range(0, 1023),
                              {$urandom, $urandom});
                else
                begin
                    if ($urandom_range(0, 19) == 0)
                        row = $urandom_range(0, nr - 1);
                    else if (row + 1 < nr && $urandom_range(0, 1) == 1)
                        row = $urandom_range(row, (row + 3 < nr) ? row + 3 : nr - 1);
                    col = $urandom_range(0, nc - 1);
                    send_load(row, col, {$urandom, $urandom});
                end
            end
            send_request(MODE_FINISH, '0, '0, '0, '0);
            if ($urandom_range(0, 9) == 0)
                send_request(MODE_FINISH, '0, '0, '0, '0);
            for (int j = 0; j < reads; j++)
            begin
                if ($urandom_range(0, 1) == 0)
                    send_read(MODE_START, ($urandom_range(0, 4) == 0)
                              ? $urandom_range(0, 4095) : $urandom_range(0, nc - 1));
                else
                    send_read(MODE_ENTRY, ($urandom_range(0, 4) == 0 || nz_loaded == 0)
                              ? $urandom_range(0, 4095) : $urandom_range(0, nz_loaded - 1));
            end
        end
    endtask

    // Main sequence.
    initial
    begin
        cfg_valid   = 1'b0;
        cfg_index   = 1'b0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        mode        = MODE_LOAD;
        src_row     = '0;
        src_col     = '0;
        src_value   = '0;
        read_index  = '0;
        shadow_rows = 11'd1024;
        shadow_cols = 11'd1024;
        nz_loaded   = 0;
        transposed  = 1'b0;
        load_rejected = 1'b0;
        fail_count  = 0;
        request_count = 0;
        result_count  = 0;
        finish_count  = 0;
        hold_left   = 0;
        quiet       = 1'b0;
        for (int k = 0; k < DIM_LIMIT; k++)
        begin
            col_tally[k]    = '0;
            t_row_starts[k] = '0;
        end
        @(posedge rst_n);

        test_early_reads();
        test_directed_cases();
        test_register_change();
        test_backpressure();
        test_random_matrices();
        test_full_rate();

        drain_block();
        repeat (20) @(posedge clk);
        $display("Sent %0d requests (%0d finishes) and checked %0d results,",
                 request_count, finish_count, result_count);
        $display("over directed cases, random matrices, a long hold-off and a full-rate run.");
        if (fail_count == 0 && pending_results.size() == 0)
            $display("** csr_matrix_transpose: PASSED **");
        else
            $display("** csr_matrix_transpose: FAILED **");
        $finish;
    end

    // Guard against a hang.
    initial
    begin
        #40_000_000;
        $display("Timed out with %0d results still expected.", pending_results.size());
        $display("** csr_matrix_transpose: FAILED **");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/ctm_pkg.sv
rtl/ctm_ram.sv
rtl/csr_matrix_transpose.sv
tb/csr_matrix_transpose_tb.sv
